// File: rtl/core/tip_pkg.sv
// ----------------------------------------------------------------------------
// tip_pkg
// Shared types and constants of the ternary im2col packer: field widths,
// register indexes, function codes, the configuration bundle and the
// sequencer states.
// ----------------------------------------------------------------------------
package tip_pkg;

	// Sample store geometry.
	localparam int SAMPLE_DEPTH = 65536;
	localparam int SAMPLE_AW    = $clog2(SAMPLE_DEPTH);
	localparam int SAMPLE_W     = 16;

	// Channel blocking.
	localparam int BLOCK_BITS   = 64;
	localparam int BLOCK_AW     = $clog2(BLOCK_BITS);
	localparam int MAX_CHANNELS = 256;
	localparam int CH_W         = 9;
	localparam int BASE_W       = 8;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	// Address arithmetic widths.
	localparam int PH_W  = 13;
	localparam int PIX_W = 18;
	localparam int LIN_W = 28;

	// Register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_HEIGHT  = 3'd0,
		REG_IMAGE_WIDTH   = 3'd1,
		REG_CHANNEL_COUNT = 3'd2,
		REG_PAD_ROWS      = 3'd3,
		REG_PAD_COLS      = 3'd4,
		REG_ROW_STRIDE    = 3'd5,
		REG_COL_STRIDE    = 3'd6,
		REG_THRESHOLD     = 3'd7
	} cfg_reg_t;

	// Item function codes.
	typedef enum logic {
		FUNC_WRITE = 1'b0,
		FUNC_READ  = 1'b1
	} func_t;

	// Configuration bundle handed to the engine.
	typedef struct packed {
		logic [8:0]  image_height;
		logic [8:0]  image_width;
		logic [8:0]  channel_count;
		logic [3:0]  pad_rows;
		logic [3:0]  pad_cols;
		logic [4:0]  row_stride;
		logic [4:0]  col_stride;
		logic [14:0] threshold;
	} cfg_t;

	// Read request fields.
	typedef struct packed {
		logic [7:0] out_row;
		logic [7:0] out_col;
		logic [3:0] kern_row;
		logic [3:0] kern_col;
		logic [1:0] chan_block;
	} rd_req_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COORD,
		ST_PIXEL,
		ST_BASE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

// File: rtl/core/tip_engine.sv
// ----------------------------------------------------------------------------
// tip_engine
// Sample store and read sequencer. Writes go straight into the store. A read
// computes the padded coordinate, the pixel index and the first linear sample
// index in ST_COORD, ST_PIXEL and ST_BASE; for a position inside the image and
// a block in use it scans the store one channel per cycle and classifies each sample against the threshold.
// ----------------------------------------------------------------------------
module tip_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tip_pkg::cfg_t                  cfg,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic                           req_func,
	input  logic [tip_pkg::SAMPLE_AW-1:0]  req_index,
	input  logic [tip_pkg::SAMPLE_W-1:0]   req_value,
	input  tip_pkg::rd_req_t               req_rd,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic [tip_pkg::BLOCK_BITS-1:0] res_negative,
	output logic [tip_pkg::BLOCK_BITS-1:0] res_nonzero
);
	import tip_pkg::*;

	state_t state_q, state_d;

	// Latched read request.
	rd_req_t rd_q;

	// Address arithmetic registers.
	logic [PH_W-1:0]  ph_q, pw_q;
	logic             inside_q;
	logic [PIX_W-1:0] pixel_q;
	logic [LIN_W-1:0] lin_q;
	logic [BLOCK_AW-1:0] idx_q;

	// Store and read pipeline.
	logic [SAMPLE_W-1:0] sample_mem [SAMPLE_DEPTH];
	logic [SAMPLE_W-1:0] rd_data_s1;
	logic                take_s1;
	logic                hit_s1;
	logic [BLOCK_AW-1:0] pos_s1;

	logic [BLOCK_BITS-1:0] neg_q, nz_q;

	// Combinational helpers.
	logic              accept;
	logic              mem_we;
	logic              rd_issue;
	logic [CH_W-1:0]   chans;
	logic [BASE_W-1:0] base;
	logic [PH_W-1:0]   ph_d, pw_d;
	logic              inside_d;
	logic [PH_W-1:0]   r_full, c_full;
	logic [PIX_W-1:0]  pixel_d;
	logic [LIN_W-1:0]  lin_d;
	logic              block_used;
	logic [CH_W-1:0]   ch_next;
	logic              scan_last;
	logic              lin_hit;
	logic signed [SAMPLE_W:0] v_ext, thr_ext;
	logic              is_pos, is_neg;

	// Handshake and channel count saturation.
	assign accept   = req_valid && req_ready;
	assign mem_we   = accept && (req_func == FUNC_WRITE);
	assign chans    = (cfg.channel_count > CH_W'(MAX_CHANNELS)) ?
	                  CH_W'(MAX_CHANNELS) : cfg.channel_count;
	assign base     = {rd_q.chan_block, {BLOCK_AW{1'b0}}};

	// Padded coordinates: output position times stride plus kernel offset.
	assign ph_d = {5'd0, rd_q.out_row} * {8'd0, cfg.row_stride} + {9'd0, rd_q.kern_row};
	assign pw_d = {5'd0, rd_q.out_col} * {8'd0, cfg.col_stride} + {9'd0, rd_q.kern_col};

	// Bounds check against the unpadded image and pixel index.
	assign inside_d = (ph_q >= {9'd0, cfg.pad_rows}) &&
	                  (ph_q < ({4'd0, cfg.image_height} + {9'd0, cfg.pad_rows})) &&
	                  (pw_q >= {9'd0, cfg.pad_cols}) &&
	                  (pw_q < ({4'd0, cfg.image_width} + {9'd0, cfg.pad_cols}));
	assign r_full   = ph_q - {9'd0, cfg.pad_rows};
	assign c_full   = pw_q - {9'd0, cfg.pad_cols};
	assign pixel_d  = {9'd0, r_full[8:0]} * {9'd0, cfg.image_width} + {9'd0, c_full[8:0]};

	// First linear sample index of the block.
	assign lin_d      = {10'd0, pixel_q} * {19'd0, chans} + {20'd0, base};
	assign block_used = ({1'b0, base} < chans);

	// Scan control: stop at the end of the block or of the channels in use.
	assign ch_next   = {1'b0, base} + {3'd0, idx_q} + CH_W'(1);
	assign scan_last = (idx_q == BLOCK_AW'(BLOCK_BITS - 1)) || (ch_next >= chans);
	assign lin_hit   = (lin_q[LIN_W-1:SAMPLE_AW] == '0);

	// Ternary classification with strict compares.
	assign v_ext   = $signed({rd_data_s1[SAMPLE_W-1], rd_data_s1});
	assign thr_ext = $signed({2'b00, cfg.threshold});
	assign is_pos  = v_ext > thr_ext;
	assign is_neg  = v_ext < -thr_ext;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (req_func == FUNC_READ)) begin
					state_d = ST_COORD;
				end
			end
			ST_COORD: state_d = ST_PIXEL;
			ST_PIXEL: state_d = ST_BASE;
			ST_BASE: begin
				if (inside_q && block_used) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		req_ready = 1'b0;
		rd_issue  = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_IDLE: req_ready = 1'b1;
			ST_SCAN: rd_issue  = 1'b1;
			ST_DONE: res_valid = 1'b1;
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			take_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			take_s1 <= rd_issue;
		end
	end

	// Request latch and address arithmetic.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= req_rd;
		end
		if (state_q == ST_COORD) begin
			ph_q <= ph_d;
			pw_q <= pw_d;
		end
		if (state_q == ST_PIXEL) begin
			inside_q <= inside_d;
			pixel_q  <= pixel_d;
		end
		if (state_q == ST_BASE) begin
			lin_q <= lin_d;
			idx_q <= '0;
		end else if (rd_issue) begin
			lin_q <= lin_q + LIN_W'(1);
			idx_q <= idx_q + BLOCK_AW'(1);
		end
	end

	// Sample store: one write or one read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			sample_mem[req_index] <= req_value;
		end
		if (rd_issue) begin
			rd_data_s1 <= sample_mem[lin_q[SAMPLE_AW-1:0]];
			hit_s1     <= lin_hit;
			pos_s1     <= idx_q;
		end
	end

	// Mask accumulation.
	always_ff @(posedge clk) begin
		if (state_q == ST_COORD) begin
			neg_q <= '0;
			nz_q  <= '0;
		end else if (take_s1 && hit_s1) begin
			if (is_pos) begin
				nz_q[pos_s1] <= 1'b1;
			end else if (is_neg) begin
				neg_q[pos_s1] <= 1'b1;
				nz_q[pos_s1]  <= 1'b1;
			end
		end
	end

	assign res_negative = neg_q;
	assign res_nonzero  = nz_q;

endmodule

// File: rtl/core/ternary_im2col_packer_core.sv
// ----------------------------------------------------------------------------
// ternary_im2col_packer_core
// Stores one image's Q8.8 activations and answers im2col reads with packed
// ternary negative and nonzero masks for a block of 64 channels.
// ----------------------------------------------------------------------------
// A write item is stored when it is taken, and the block takes the next
// item in the following cycle. A read item runs the address arithmetic in
// order (coordinate, pixel index, linear index), then, for a position inside
// the image and a block in use, scans the channels of the block in the store
// and drains the read pipeline; a padding position or unused block skips the
// scan. The result then goes to the output register, and the next item is
// taken after that. The single-port sample store, read one sample per cycle,
// sets the length of the scan. A full output register that is not being
// drained holds the hand-off cycle. Items are handled one at a time, but a
// new item is taken while the previous result still waits in the output
// register.
module ternary_im2col_packer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [tip_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tip_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              func,
	input  logic [15:0]                       sample_index,
	input  logic signed [15:0]                sample_value,
	input  logic [7:0]                        out_row,
	input  logic [7:0]                        out_col,
	input  logic [3:0]                        kern_row,
	input  logic [3:0]                        kern_col,
	input  logic [1:0]                        chan_block,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [tip_pkg::BLOCK_BITS-1:0]    negative_mask,
	output logic [tip_pkg::BLOCK_BITS-1:0]    nonzero_mask
);
	import tip_pkg::*;

	cfg_t    cfg_q;
	rd_req_t rd_req;

	logic                  res_valid;
	logic                  res_ready;
	logic [BLOCK_BITS-1:0] res_negative;
	logic [BLOCK_BITS-1:0] res_nonzero;

	logic                  out_valid_q;
	logic [BLOCK_BITS-1:0] negative_q;
	logic [BLOCK_BITS-1:0] nonzero_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_height  <= 9'd1;
			cfg_q.image_width   <= 9'd1;
			cfg_q.channel_count <= 9'd1;
			cfg_q.pad_rows      <= 4'd0;
			cfg_q.pad_cols      <= 4'd0;
			cfg_q.row_stride    <= 5'd1;
			cfg_q.col_stride    <= 5'd1;
			cfg_q.threshold     <= 15'd0;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data[8:0];
				REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data[8:0];
				REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data[8:0];
				REG_PAD_ROWS:      cfg_q.pad_rows      <= cfg_data[3:0];
				REG_PAD_COLS:      cfg_q.pad_cols      <= cfg_data[3:0];
				REG_ROW_STRIDE:    cfg_q.row_stride    <= cfg_data[4:0];
				REG_COL_STRIDE:    cfg_q.col_stride    <= cfg_data[4:0];
				REG_THRESHOLD:     cfg_q.threshold     <= cfg_data[14:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// Read request fields travel together.
	assign rd_req.out_row    = out_row;
	assign rd_req.out_col    = out_col;
	assign rd_req.kern_row   = kern_row;
	assign rd_req.kern_col   = kern_col;
	assign rd_req.chan_block = chan_block;

	tip_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.req_valid    (in_valid),
		.req_ready    (in_ready),
		.req_func     (func),
		.req_index    (sample_index),
		.req_value    (sample_value),
		.req_rd       (rd_req),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res_negative (res_negative),
		.res_nonzero  (res_nonzero)
	);

	// Output register: the slot takes a new result when empty or being drained.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			negative_q <= res_negative;
			nonzero_q  <= res_nonzero;
		end
	end

	assign out_valid     = out_valid_q;
	assign negative_mask = negative_q;
	assign nonzero_mask  = nonzero_q;

endmodule

// File: rtl/core/tip_checker.sv
// ----------------------------------------------------------------------------
// tip_checker
// Port-level checks of the ternary im2col packer, attached to the top level.
// ----------------------------------------------------------------------------
module tip_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic                           func,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [tip_pkg::BLOCK_BITS-1:0] negative_mask,
	input  logic [tip_pkg::BLOCK_BITS-1:0] nonzero_mask
);
	import tip_pkg::*;

	// A negative channel is always also a nonzero channel.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((negative_mask & ~nonzero_mask) == '0))
	else $error("negative bit without nonzero bit");

	// A write item leaves the block ready in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (func == FUNC_WRITE)) |=> in_ready)
	else $error("block busy after a write item");

	// A read item occupies the sequencer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (func == FUNC_READ)) |=> !in_ready)
	else $error("block ready right after a read item");

	// A new result only follows a busy cycle of the sequencer.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
	else $error("result appeared without a read in progress");

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(negative_mask) && $stable(nonzero_mask)))
	else $error("stalled result changed");

endmodule

bind ternary_im2col_packer_core tip_checker u_tip_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.func          (func),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.negative_mask (negative_mask),
	.nonzero_mask  (nonzero_mask)
);
